@@ src/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared widths, payload types and helpers of the triangle tangent block.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int UNIT_WIDTH  = 16;
    localparam int THR_WIDTH   = 16;

    // Wide coordinates drop low edge bits so every product fits the multiplier.
    localparam int EDGE_DROP  = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
    localparam int EDGE_WIDTH = (COORD_WIDTH > 30) ? 31 : COORD_WIDTH + 1;
    localparam int UNIT_FRAC  = UNIT_WIDTH - 2;

    localparam int MUL_WIDTH  = 32;
    localparam int WORD_WIDTH = 64;

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic signed [COORD_WIDTH-1:0] tex_u;
        logic signed [COORD_WIDTH-1:0] tex_v;
        logic        [1:0]             corner;
    } t_in_item;

    typedef struct packed {
        logic signed [UNIT_WIDTH-1:0] tangent_x;
        logic signed [UNIT_WIDTH-1:0] tangent_y;
        logic signed [UNIT_WIDTH-1:0] tangent_z;
        logic signed [UNIT_WIDTH-1:0] bitangent_x;
        logic signed [UNIT_WIDTH-1:0] bitangent_y;
        logic signed [UNIT_WIDTH-1:0] bitangent_z;
        logic                         degenerate;
    } t_out_item;

    typedef struct packed {
        logic signed [EDGE_WIDTH-1:0] ea_x;
        logic signed [EDGE_WIDTH-1:0] ea_y;
        logic signed [EDGE_WIDTH-1:0] ea_z;
        logic signed [EDGE_WIDTH-1:0] eb_x;
        logic signed [EDGE_WIDTH-1:0] eb_y;
        logic signed [EDGE_WIDTH-1:0] eb_z;
        logic signed [EDGE_WIDTH-1:0] du1;
        logic signed [EDGE_WIDTH-1:0] dv1;
        logic signed [EDGE_WIDTH-1:0] du2;
        logic signed [EDGE_WIDTH-1:0] dv2;
    } t_edges;

    // Difference a - b, shifted right toward minus infinity.
    function automatic logic signed [EDGE_WIDTH-1:0] f_edge(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] d;
        logic signed [COORD_WIDTH:0] s;
        d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
        s = d >>> EDGE_DROP;
        return s[EDGE_WIDTH-1:0];
    endfunction

endpackage

@@ src/ttb_mul.sv @@
// ----------------------------------------------------------------------------
// ttb_mul
// Registered signed multiplier shared by all products of the sequencer.
// ----------------------------------------------------------------------------
module ttb_mul (
    input  logic                                  i_clk,
    input  logic signed [ttb_pkg::MUL_WIDTH-1:0]  i_a,
    input  logic signed [ttb_pkg::MUL_WIDTH-1:0]  i_b,
    output logic signed [ttb_pkg::WORD_WIDTH-1:0] o_p
);
    import ttb_pkg::*;

    logic signed [WORD_WIDTH-1:0] r_p;

    // The full double-width product; both operands extend with their sign.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ src/ttb_seq.sv @@
// ----------------------------------------------------------------------------
// ttb_seq
// Sequencer: products, degeneracy test, scaling, square root and division.
// ----------------------------------------------------------------------------
module ttb_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  ttb_pkg::t_edges              i_edges,
    input  logic [ttb_pkg::THR_WIDTH-1:0] i_threshold,
    input  logic                         i_take,
    output logic                         o_busy,
    output logic                         o_done,
    output ttb_pkg::t_out_item           o_result
);
    import ttb_pkg::*;

    localparam int QW         = UNIT_FRAC + 2;
    localparam int KW         = $clog2(QW);
    localparam int ROOT_STEPS = WORD_WIDTH / 2;
    localparam int RW         = $clog2(ROOT_STEPS);
    localparam logic [WORD_WIDTH-1:0] LOW_MARK  = WORD_WIDTH'(1) << 29;
    localparam logic [WORD_WIDTH-1:0] HIGH_MARK = WORD_WIDTH'(1) << 30;
    localparam logic [WORD_WIDTH-1:0] ROOT_BIT  = WORD_WIDTH'(1) << (WORD_WIDTH - 2);
    localparam logic [WORD_WIDTH-1:0] ONE_WORD  = WORD_WIDTH'(1) << UNIT_FRAC;
    localparam logic signed [UNIT_WIDTH-1:0] ONE_UNIT = UNIT_WIDTH'(1) << UNIT_FRAC;
    localparam logic [2:0] LAST_PAIR = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_CHECK, S_ABS, S_SHIFT, S_SQ, S_SQACC,
        S_ROOT, S_DIVINIT, S_DIV, S_DIVEND, S_NEXT, S_DONE
    } t_state;

    t_state                         r_state;
    t_edges                         r_e;
    logic [2:0]                     r_pair;
    logic                           r_half;
    logic signed [WORD_WIDTH-1:0]   r_acc;
    logic signed [WORD_WIDTH-1:0]   r_det;
    logic signed [WORD_WIDTH-1:0]   r_tv [3];
    logic signed [WORD_WIDTH-1:0]   r_bv [3];
    logic                           r_vsel;
    logic [WORD_WIDTH-1:0]          r_m [3];
    logic [2:0]                     r_neg;
    logic [WORD_WIDTH-1:0]          r_mx;
    logic [1:0]                     r_i;
    logic [WORD_WIDTH-1:0]          r_sum;
    logic [WORD_WIDTH-1:0]          r_n;
    logic [WORD_WIDTH-1:0]          r_r;
    logic [WORD_WIDTH-1:0]          r_b;
    logic [RW-1:0]                  r_cnt;
    logic [WORD_WIDTH-1:0]          r_rem;
    logic [WORD_WIDTH-1:0]          r_dsh;
    logic [QW-1:0]                  r_q;
    logic [KW-1:0]                  r_k;
    logic signed [UNIT_WIDTH-1:0]   r_tu [3];
    logic signed [UNIT_WIDTH-1:0]   r_bu [3];
    logic                           r_degen;

    logic signed [MUL_WIDTH-1:0]    w_a;
    logic signed [MUL_WIDTH-1:0]    w_b;
    logic signed [WORD_WIDTH-1:0]   w_p;
    logic signed [WORD_WIDTH-1:0]   w_v [3];
    logic [WORD_WIDTH-1:0]          w_abs [3];
    logic [WORD_WIDTH-1:0]          w_max;
    logic [WORD_WIDTH-1:0]          w_absdet;
    logic [WORD_WIDTH-1:0]          w_rb;
    logic [WORD_WIDTH-1:0]          w_qc;
    logic signed [UNIT_WIDTH-1:0]   w_u;

    ttb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    function automatic logic signed [MUL_WIDTH-1:0] f_ext(
        input logic signed [EDGE_WIDTH-1:0] x
    );
        return MUL_WIDTH'(x);
    endfunction

    // Operand selection: pair 0 is the determinant, 1-3 the tangent, 4-6 the
    // bitangent; the first product of a pair is added, the second subtracted.
    always_comb begin
        w_a = '0;
        w_b = '0;
        if (r_state == S_SQ || r_state == S_SQACC) begin
            w_a = $signed(r_m[r_i][MUL_WIDTH-1:0]);
            w_b = $signed(r_m[r_i][MUL_WIDTH-1:0]);
        end else begin
            unique case (r_pair)
                3'd0: begin
                    w_a = r_half ? f_ext(r_e.du2) : f_ext(r_e.du1);
                    w_b = r_half ? f_ext(r_e.dv1) : f_ext(r_e.dv2);
                end
                3'd1: begin
                    w_a = r_half ? f_ext(r_e.dv1)  : f_ext(r_e.dv2);
                    w_b = r_half ? f_ext(r_e.eb_x) : f_ext(r_e.ea_x);
                end
                3'd2: begin
                    w_a = r_half ? f_ext(r_e.dv1)  : f_ext(r_e.dv2);
                    w_b = r_half ? f_ext(r_e.eb_y) : f_ext(r_e.ea_y);
                end
                3'd3: begin
                    w_a = r_half ? f_ext(r_e.dv1)  : f_ext(r_e.dv2);
                    w_b = r_half ? f_ext(r_e.eb_z) : f_ext(r_e.ea_z);
                end
                3'd4: begin
                    w_a = r_half ? f_ext(r_e.du2)  : f_ext(r_e.du1);
                    w_b = r_half ? f_ext(r_e.ea_x) : f_ext(r_e.eb_x);
                end
                3'd5: begin
                    w_a = r_half ? f_ext(r_e.du2)  : f_ext(r_e.du1);
                    w_b = r_half ? f_ext(r_e.ea_y) : f_ext(r_e.eb_y);
                end
                3'd6: begin
                    w_a = r_half ? f_ext(r_e.du2)  : f_ext(r_e.du1);
                    w_b = r_half ? f_ext(r_e.ea_z) : f_ext(r_e.eb_z);
                end
                default: begin
                    w_a = '0;
                    w_b = '0;
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i]   = r_vsel ? r_bv[i] : r_tv[i];
            w_abs[i] = w_v[i][WORD_WIDTH-1] ? WORD_WIDTH'(-w_v[i]) : WORD_WIDTH'(w_v[i]);
        end
        w_max = w_abs[0];
        if (w_abs[1] > w_max) begin
            w_max = w_abs[1];
        end
        if (w_abs[2] > w_max) begin
            w_max = w_abs[2];
        end
        w_absdet = r_det[WORD_WIDTH-1] ? WORD_WIDTH'(-r_det) : WORD_WIDTH'(r_det);
        w_rb = r_r + r_b;
        w_qc = (WORD_WIDTH'(r_q) > ONE_WORD) ? ONE_WORD : WORD_WIDTH'(r_q);
        w_u  = r_neg[r_i] ? -$signed(w_qc[UNIT_WIDTH-1:0]) : $signed(w_qc[UNIT_WIDTH-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_e     <= i_edges;
                        r_pair  <= '0;
                        r_half  <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_half) begin
                        r_acc   <= w_p;
                        r_half  <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        unique case (r_pair)
                            3'd0:    r_det   <= r_acc - w_p;
                            3'd1:    r_tv[0] <= r_acc - w_p;
                            3'd2:    r_tv[1] <= r_acc - w_p;
                            3'd3:    r_tv[2] <= r_acc - w_p;
                            3'd4:    r_bv[0] <= r_acc - w_p;
                            3'd5:    r_bv[1] <= r_acc - w_p;
                            default: r_bv[2] <= r_acc - w_p;
                        endcase
                        r_half  <= 1'b0;
                        r_pair  <= r_pair + 3'd1;
                        r_state <= (r_pair == LAST_PAIR) ? S_CHECK : S_MUL;
                    end
                end
                S_CHECK: begin
                    r_vsel <= 1'b0;
                    if (w_absdet <= WORD_WIDTH'(i_threshold)) begin
                        r_degen <= 1'b1;
                        r_tu[0] <= ONE_UNIT;
                        r_tu[1] <= '0;
                        r_tu[2] <= '0;
                        r_bu[0] <= '0;
                        r_bu[1] <= '0;
                        r_bu[2] <= -ONE_UNIT;
                        r_state <= S_DONE;
                    end else begin
                        r_degen <= 1'b0;
                        if (r_det[WORD_WIDTH-1]) begin
                            for (int i = 0; i < 3; i++) begin
                                r_tv[i] <= -r_tv[i];
                                r_bv[i] <= -r_bv[i];
                            end
                        end
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i]   <= w_abs[i];
                        r_neg[i] <= w_v[i][WORD_WIDTH-1];
                    end
                    r_mx <= w_max;
                    if (w_max == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_vsel) begin
                                r_bu[i] <= '0;
                            end else begin
                                r_tu[i] <= '0;
                            end
                        end
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
                    if (r_mx < LOW_MARK) begin
                        r_mx <= r_mx << 1;
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] << 1;
                        end
                    end else if (r_mx >= HIGH_MARK) begin
                        r_mx <= r_mx >> 1;
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else begin
                        r_i     <= '0;
                        r_sum   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQACC;
                end
                S_SQACC: begin
                    if (r_i == 2'd2) begin
                        r_n     <= r_sum + WORD_WIDTH'(w_p);
                        r_r     <= '0;
                        r_b     <= ROOT_BIT;
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_sum   <= r_sum + WORD_WIDTH'(w_p);
                        r_i     <= r_i + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_ROOT: begin
                    // Bit-pair square root; leading steps with r = 0 act as the
                    // search for the starting bit.
                    if (r_n >= w_rb) begin
                        r_n <= r_n - w_rb;
                        r_r <= (r_r >> 1) + r_b;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_b   <= r_b >> 2;
                    r_cnt <= r_cnt + RW'(1);
                    if (r_cnt == RW'(ROOT_STEPS - 1)) begin
                        r_i     <= '0;
                        r_state <= S_DIVINIT;
                    end
                end
                S_DIVINIT: begin
                    r_rem   <= (r_m[r_i] << UNIT_FRAC) + (r_r >> 1);
                    r_dsh   <= r_r << (QW - 1);
                    r_q     <= '0;
                    r_k     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_k   <= r_k + KW'(1);
                    if (r_k == KW'(QW - 1)) begin
                        r_state <= S_DIVEND;
                    end
                end
                S_DIVEND: begin
                    if (r_vsel) begin
                        r_bu[r_i] <= w_u;
                    end else begin
                        r_tu[r_i] <= w_u;
                    end
                    if (r_i == 2'd2) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_DIVINIT;
                    end
                end
                S_NEXT: begin
                    if (!r_vsel) begin
                        r_vsel  <= 1'b1;
                        r_state <= S_ABS;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign o_result.tangent_x   = r_tu[0];
    assign o_result.tangent_y   = r_tu[1];
    assign o_result.tangent_z   = r_tu[2];
    assign o_result.bitangent_x = r_bu[0];
    assign o_result.bitangent_y = r_bu[1];
    assign o_result.bitangent_z = r_bu[2];
    assign o_result.degenerate  = r_degen;

`ifndef NO_ASSERTIONS
    // A finished result waits for the output register.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_take) |=> (r_state == S_DONE))
        else $error("result left before it was taken");

    // The remainder always stays below twice the shifted divisor.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < (r_dsh << 1)))
        else $error("division remainder out of range");

    // The scaling pass ends with the largest magnitude in range.
    a_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (r_mx >= LOW_MARK && r_mx < HIGH_MARK))
        else $error("scaling pass ended out of range");
`endif

endmodule

@@ src/triangle_tangent_bitangent_top.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_top
// Tangent and bitangent of a triangle from its corner positions and uv.
// ----------------------------------------------------------------------------
// Corners arrive one request at a time on the input channel (valid/stall).
// Corners 0 and 1 are held; a corner code of 3 is dropped. Corner 2 starts
// the sequencer, which stalls the input until the result has moved to the
// output register. All products go through one registered 32x32
// multiplier, then iterative units run scaling, root and division. For
// corner 2 the sequencer forms the products and tests the determinant; a
// degenerate triangle goes straight to handing over the result. Otherwise
// each of the two vectors passes through the magnitude step, the scaling
// shift (one bit per cycle), the squares, the root and the division before
// the result is handed over; a zero vector skips all but the magnitude
// step. The output channel (valid/stall) holds its request while the
// receiver stalls; the sequencer then waits with its finished result. The
// threshold register is written through the config channel, which is
// always ready. Reset is synchronous: it clears the threshold, the sequencer
// and the output valid; held corners stay undefined until written.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ttb_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ttb_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ttb_pkg::THR_WIDTH-1:0] i_cfg_data
);
    import ttb_pkg::*;

    logic [THR_WIDTH-1:0] r_thr;
    t_in_item             r_c0;
    t_in_item             r_c1;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 w_accept;
    logic                 w_start;
    logic                 w_take;
    logic                 w_busy;
    logic                 w_done;
    t_edges               w_edges;
    t_out_item            w_result;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_start  = w_accept && (i_in.corner == CORNER_2);
    assign w_take   = !r_out_valid || !i_out_stall;

    always_comb begin
        w_edges.ea_x = f_edge(r_c1.pos_x, r_c0.pos_x);
        w_edges.ea_y = f_edge(r_c1.pos_y, r_c0.pos_y);
        w_edges.ea_z = f_edge(r_c1.pos_z, r_c0.pos_z);
        w_edges.eb_x = f_edge(i_in.pos_x, r_c0.pos_x);
        w_edges.eb_y = f_edge(i_in.pos_y, r_c0.pos_y);
        w_edges.eb_z = f_edge(i_in.pos_z, r_c0.pos_z);
        w_edges.du1  = f_edge(r_c1.tex_u, r_c0.tex_u);
        w_edges.dv1  = f_edge(r_c1.tex_v, r_c0.tex_v);
        w_edges.du2  = f_edge(i_in.tex_u, r_c0.tex_u);
        w_edges.dv2  = f_edge(i_in.tex_v, r_c0.tex_v);
    end

    ttb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_edges     (w_edges),
        .i_threshold (r_thr),
        .i_take      (w_take),
        .o_busy      (w_busy),
        .o_done      (w_done),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.corner == CORNER_0) begin
            r_c0 <= i_in;
        end
        if (w_accept && i_in.corner == CORNER_1) begin
            r_c1 <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_done) begin
            r_out <= w_result;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

@@ bench/tb_triangle_tangent_bitangent_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_bitangent_top
// Self-checking bench for the triangle tangent and bitangent block.
// ----------------------------------------------------------------------------
// Corner requests are driven from a directed table and then from random
// triangles. A predictor computes the unit vectors of each completed triangle
// and its result is compared with the block's output. Both sides idle at
// random in two of three phases; the threshold is rewritten between them.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_bitangent_top;
    import ttb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [THR_WIDTH-1:0] i_cfg_data = '0;

    triangle_tangent_bitangent_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state.
    logic [THR_WIDTH-1:0] thr_model;
    longint held_pos[6];
    longint held_tex[4];

    t_out_item frame_queue[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  corner0_seen, corner1_seen;

    function automatic longint unit_edge(longint a, longint b);
        longint d;
        d = a - b;
        return d >>> EDGE_DROP;
    endfunction

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    task automatic normalize_vec(input longint v[3], output logic signed [UNIT_WIDTH-1:0] u[3]);
        longint m[3], mx, sum, len, q, one;
        one = longint'(1) << UNIT_FRAC;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) u[i] = '0;
            return;
        end
        while (mx < (longint'(1) << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        while (mx >= (longint'(1) << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << UNIT_FRAC) + (len >> 1)) / len;
            if (q > one) q = one;
            u[i] = UNIT_WIDTH'(v[i] < 0 ? -q : q);
        end
    endtask

    // Applies one accepted corner; returns 1 with the tangent frame on corner 2.
    task automatic predict_frame(input t_in_item c, output bit has_frame, output t_out_item f);
        longint p[3], ea[3], eb[3], tv[3], bv[3];
        longint du1, dv1, du2, dv2, det, mag;
        logic signed [UNIT_WIDTH-1:0] tu[3], bu[3];
        p[0] = c.pos_x; p[1] = c.pos_y; p[2] = c.pos_z;
        has_frame = 1'b0;
        f = '0;
        if (c.corner == CORNER_0 || c.corner == CORNER_1) begin
            for (int i = 0; i < 3; i++) held_pos[c.corner * 3 + i] = p[i];
            held_tex[c.corner * 2]     = c.tex_u;
            held_tex[c.corner * 2 + 1] = c.tex_v;
            return;
        end
        if (c.corner != CORNER_2) return;
        for (int i = 0; i < 3; i++) begin
            ea[i] = unit_edge(held_pos[3 + i], held_pos[i]);
            eb[i] = unit_edge(p[i], held_pos[i]);
        end
        du1 = unit_edge(held_tex[2], held_tex[0]);
        dv1 = unit_edge(held_tex[3], held_tex[1]);
        du2 = unit_edge(c.tex_u, held_tex[0]);
        dv2 = unit_edge(c.tex_v, held_tex[1]);
        det = du1 * dv2 - du2 * dv1;
        mag = det < 0 ? -det : det;
        has_frame = 1'b1;
        if (mag <= longint'(thr_model)) begin
            f.tangent_x   = UNIT_WIDTH'(1 << UNIT_FRAC);
            f.bitangent_z = -UNIT_WIDTH'(1 << UNIT_FRAC);
            f.degenerate  = 1'b1;
            return;
        end
        for (int i = 0; i < 3; i++) begin
            tv[i] = dv2 * ea[i] - dv1 * eb[i];
            bv[i] = du1 * eb[i] - du2 * ea[i];
            if (det < 0) begin
                tv[i] = -tv[i];
                bv[i] = -bv[i];
            end
        end
        normalize_vec(tv, tu);
        normalize_vec(bv, bu);
        f.tangent_x = tu[0]; f.tangent_y = tu[1]; f.tangent_z = tu[2];
        f.bitangent_x = bu[0]; f.bitangent_y = bu[1]; f.bitangent_z = bu[2];
        f.degenerate = 1'b0;
    endtask

    // Output checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else if (o_out_valid && !i_out_stall) begin
                if (frame_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out);
                    fail_count <= fail_count + 1;
                end else if (frame_queue[0] !== o_out) begin
                    $display("%0t: mismatch expected %h actual %h",
                             $time, frame_queue[0], o_out);
                    fail_count <= fail_count + 1;
                    void'(frame_queue.pop_front());
                end else begin
                    void'(frame_queue.pop_front());
                end
            end
        end
    end

    // Receiver stall, changed at the falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_corner(input t_in_item c);
        bit has_frame;
        t_out_item f;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= c;
        // The stall only moves at a rising edge, so the value seen here holds
        // up to the next rising edge.
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        predict_frame(c, has_frame, f);
        if (has_frame) frame_queue = {frame_queue, f};
        if (c.corner == CORNER_0) corner0_seen = 1'b1;
        if (c.corner == CORNER_1) corner1_seen = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
        i_in_valid <= 1'b0;
        while (frame_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        thr_model = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord(input bit narrow);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return COORD_WIDTH'(16'sh7fff);
        if (sel == 1) return COORD_WIDTH'(16'sh8000);
        if (narrow) return COORD_WIDTH'($signed($urandom_range(8191)) - 4096);
        return COORD_WIDTH'($urandom);
    endfunction

    function automatic t_in_item rand_corner(input logic [1:0] k, input bit narrow);
        t_in_item c;
        c.pos_x = rand_coord(narrow);
        c.pos_y = rand_coord(narrow);
        c.pos_z = rand_coord(narrow);
        c.tex_u = rand_coord(narrow);
        c.tex_v = rand_coord(narrow);
        c.corner = k;
        return c;
    endfunction

    // Directed rows: corner fields, expected frame where obvious, and a flag.
    typedef struct {
        t_in_item  c;
        bit        typed;
        t_out_item f;
    } t_row;

    t_row dir_rows[$];

    task automatic add_row(input logic signed [15:0] x, y, z, u, v,
                           input logic [1:0] k, input bit typed, input t_out_item f);
        t_row r;
        r.c = '{x, y, z, u, v, k};
        r.typed = typed;
        r.f = f;
        dir_rows = {dir_rows, r};
    endtask

    t_out_item default_frame;
    t_out_item no_frame;

    initial begin
        int phase_items;
        t_in_item c;
        no_frame = '0;
        default_frame = '0;
        default_frame.tangent_x = 16'sd16384;
        default_frame.bitangent_z = -16'sd16384;
        default_frame.degenerate = 1'b1;
        thr_model = '0;
        for (int i = 0; i < 6; i++) held_pos[i] = 0;
        for (int i = 0; i < 4; i++) held_tex[i] = 0;

        // All corners equal: zero determinant, so the default frame.
        add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, CORNER_0, 0, no_frame);
        add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, CORNER_1, 0, no_frame);
        add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, CORNER_2, 1, default_frame);
        // Unit right triangle in uv.
        add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, CORNER_0, 0, no_frame);
        add_row(16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, CORNER_1, 0, no_frame);
        add_row(16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096, CORNER_2, 0, no_frame);
        // Extremes of every field, with a corner code of 3 in between.
        add_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, CORNER_0, 0, no_frame);
        add_row(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, CORNER_1, 0, no_frame);
        add_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 2'd3, 0, no_frame);
        add_row(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, CORNER_2, 0, no_frame);
        // Second corner 2 with the uv of corner 1: zero determinant.
        add_row(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, CORNER_2, 0, no_frame);
        // Repeated corner 1 overwrites; collinear positions give a zero vector.
        add_row(16'sd100, 16'sd100, 16'sd100, 16'sd0, 16'sd0, CORNER_0, 0, no_frame);
        add_row(16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9, CORNER_1, 0, no_frame);
        add_row(16'sd100, 16'sd100, 16'sd100, 16'sd1, 16'sd0, CORNER_1, 0, no_frame);
        add_row(16'sd100, 16'sd100, 16'sd100, 16'sd0, 16'sd1, CORNER_2, 0, no_frame);
        // Determinant of exactly one step against a threshold of zero.
        add_row(16'sd5, -16'sd7, 16'sd3, 16'sd0, 16'sd1, CORNER_2, 0, no_frame);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            send_corner(dir_rows[i].c);
            if (dir_rows[i].typed && frame_queue.size() != 0 &&
                frame_queue[$] !== dir_rows[i].f) begin
                $display("%0t: table mismatch expected %h actual %h",
                         $time, dir_rows[i].f, frame_queue[$]);
                fail_count++;
            end
        end

        // Threshold of one: a unit determinant now counts as degenerate.
        write_threshold(16'd1);
        send_corner(dir_rows[15].c);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 22; recv_idle_pct = 71;
                    write_threshold(16'hffff);
                end
                1: begin
                    send_idle_pct = 71; recv_idle_pct = 22;
                    write_threshold(16'($urandom_range(4095)));
                end
                default: begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                    write_threshold(16'd0);
                end
            endcase
            phase_items = 0;
            while (phase_items < 233) begin
                if ($urandom_range(9) < 8 || !(corner0_seen && corner1_seen)) begin
                    bit narrow;
                    narrow = $urandom_range(1);
                    for (int k = 0; k < 3; k++) send_corner(rand_corner(2'(k), narrow));
                    phase_items += 3;
                end else begin
                    c = rand_corner(2'($urandom_range(3)), $urandom_range(1));
                    send_corner(c);
                    phase_items += 1;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (frame_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && frame_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
